>>> design/quad_motor_mixer_throttle_defines.svh
// assertion macros for the quad motor mixer throttle block
`ifndef QUAD_MOTOR_MIXER_THROTTLE_DEFINES_SVH
`define QUAD_MOTOR_MIXER_THROTTLE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define QMM_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define QMM_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> design/qmm_pkg.sv
// shared types, widths and constants of the quad motor mixer throttle block
package qmm_pkg;

   localparam int IN_W      = 32;
   localparam int GAIN_W    = 26;
   localparam int OFFSET_W  = 24;
   localparam int SLOPE_W   = 16;
   localparam int THR_W     = 10;
   localparam int LANES     = 4;

   localparam int LANE_BL   = 0;
   localparam int LANE_FL   = 1;
   localparam int LANE_BR   = 2;
   localparam int LANE_FR   = 3;

   localparam int PROD_W    = IN_W + GAIN_W + 1;
   localparam int PAIR_W    = PROD_W + 1;
   localparam int SUM_W     = PAIR_W + 1;
   localparam int RAD_W     = SUM_W - 1;
   localparam int ROOT_W    = RAD_W / 2;
   localparam int REM_W     = ROOT_W + 2;
   localparam int SQRT_BITS_PER_STAGE = 2;
   localparam int SQRT_STAGES = ROOT_W / SQRT_BITS_PER_STAGE;

   localparam int DIFF_W    = ROOT_W + 1;
   localparam int CURVE_W   = DIFF_W + SLOPE_W + 1;
   localparam int CURVE_FRAC = 24;
   localparam int WHOLE_W   = CURVE_W - CURVE_FRAC;
   localparam int CROSS_THROTTLE = 350;

   localparam int CSR_INDEX_W = 4;

   typedef logic [GAIN_W-1:0]   gain_type;
   typedef logic [OFFSET_W-1:0] offset_type;
   typedef logic [SLOPE_W-1:0]  slope_type;
   typedef logic [RAD_W-1:0]    rad_type;
   typedef logic [ROOT_W-1:0]   root_type;
   typedef logic [THR_W-1:0]    throttle_type;

   localparam throttle_type THROTTLE_MAX = THR_W'(1000);
   localparam logic signed [CURVE_W-1:0] CROSSOVER =
      CURVE_W'(CROSS_THROTTLE) << CURVE_FRAC;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_ROLL_GAIN,
      REG_PITCH_GAIN,
      REG_YAW_GAIN,
      REG_THRUST_GAIN,
      REG_LOW_OFFSET,
      REG_LOW_INV_SLOPE,
      REG_HIGH_OFFSET,
      REG_HIGH_INV_SLOPE
   } reg_index_type;

   typedef struct packed {
      gain_type   roll_gain;
      gain_type   pitch_gain;
      gain_type   yaw_gain;
      gain_type   thrust_gain;
      offset_type low_offset;
      slope_type  low_inv_slope;
      offset_type high_offset;
      slope_type  high_inv_slope;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      roll_gain:      GAIN_W'(2631579),
      pitch_gain:     GAIN_W'(2808989),
      yaw_gain:       GAIN_W'(22727273),
      thrust_gain:    GAIN_W'(250000),
      low_offset:     OFFSET_W'(3110),
      low_inv_slope:  SLOPE_W'(26975),
      high_offset:    OFFSET_W'(22010),
      high_inv_slope: SLOPE_W'(29660)
   };

endpackage

>>> design/quad_motor_mixer_throttle.sv
// X-frame quad motor mixer with square root and inverse motor curve to throttle
//
// Takes one transaction per clock while no stage is stalled and delivers results in order
// through 3 mixer stages (32x27 gain products, pair sums, rotor sums), 15
// square root stages resolving two root bits each, and 3 curve stages (offset,
// 31x17 slope product, segment pick and clamp into the output register). Every
// stage holds a valid bit and only stalls when the stage after it is full, so
// req_ready drops only once the whole pipeline is full behind a held result.
// csr_ready is always high; registers may only be written while no transaction
// is in flight.
`include "quad_motor_mixer_throttle_defines.svh"

module quad_motor_mixer_throttle (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic signed [qmm_pkg::IN_W-1:0]        req_thrust,
   input  logic signed [qmm_pkg::IN_W-1:0]        req_roll_moment,
   input  logic signed [qmm_pkg::IN_W-1:0]        req_pitch_moment,
   input  logic signed [qmm_pkg::IN_W-1:0]        req_yaw_moment,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [qmm_pkg::THR_W-1:0]              rsp_throttle_back_left,
   output logic [qmm_pkg::THR_W-1:0]              rsp_throttle_front_left,
   output logic [qmm_pkg::THR_W-1:0]              rsp_throttle_back_right,
   output logic [qmm_pkg::THR_W-1:0]              rsp_throttle_front_right,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [qmm_pkg::CSR_INDEX_W-1:0]        csr_index,
   input  logic [qmm_pkg::GAIN_W-1:0]             csr_data
);
   import qmm_pkg::*;

   cfg_type cfg_ff;

   logic mix_valid, sqrt_ready;
   logic sqrt_valid, curve_ready;
   rad_type      [LANES-1:0] rad;
   root_type     [LANES-1:0] root;
   throttle_type [LANES-1:0] throttle;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else if (csr_valid && csr_ready) begin
         case (reg_index_type'(csr_index))
            REG_ROLL_GAIN:      cfg_ff.roll_gain      <= csr_data;
            REG_PITCH_GAIN:     cfg_ff.pitch_gain     <= csr_data;
            REG_YAW_GAIN:       cfg_ff.yaw_gain       <= csr_data;
            REG_THRUST_GAIN:    cfg_ff.thrust_gain    <= csr_data;
            REG_LOW_OFFSET:     cfg_ff.low_offset     <= csr_data[OFFSET_W-1:0];
            REG_LOW_INV_SLOPE:  cfg_ff.low_inv_slope  <= csr_data[SLOPE_W-1:0];
            REG_HIGH_OFFSET:    cfg_ff.high_offset    <= csr_data[OFFSET_W-1:0];
            REG_HIGH_INV_SLOPE: cfg_ff.high_inv_slope <= csr_data[SLOPE_W-1:0];
            default: ;
         endcase
      end
   end

   qmm_mix u_mix (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (req_valid),
      .in_ready     (req_ready),
      .thrust       (req_thrust),
      .roll_moment  (req_roll_moment),
      .pitch_moment (req_pitch_moment),
      .yaw_moment   (req_yaw_moment),
      .cfg          (cfg_ff),
      .out_valid    (mix_valid),
      .out_ready    (sqrt_ready),
      .rad          (rad)
   );

   qmm_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (mix_valid),
      .in_ready  (sqrt_ready),
      .rad       (rad),
      .out_valid (sqrt_valid),
      .out_ready (curve_ready),
      .root      (root)
   );

   qmm_curve u_curve (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sqrt_valid),
      .in_ready  (curve_ready),
      .root      (root),
      .cfg       (cfg_ff),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .throttle  (throttle)
   );

   assign rsp_throttle_back_left   = throttle[LANE_BL];
   assign rsp_throttle_front_left  = throttle[LANE_FL];
   assign rsp_throttle_back_right  = throttle[LANE_BR];
   assign rsp_throttle_front_right = throttle[LANE_FR];

   `QMM_ASSERT_IMP(a_throttle_range, clock, reset, rsp_valid,
      (rsp_throttle_back_left <= THROTTLE_MAX) && (rsp_throttle_front_left <= THROTTLE_MAX)
      && (rsp_throttle_back_right <= THROTTLE_MAX) && (rsp_throttle_front_right <= THROTTLE_MAX),
      "throttle above full scale")
   `QMM_ASSERT_IMP(a_stall_only_when_full, clock, reset, !req_ready,
      rsp_valid && !rsp_ready, "input stalled without a held result")
   `QMM_ASSERT_NXT(a_mix_holds, clock, reset, mix_valid && !sqrt_ready,
      mix_valid, "mixer output dropped while stalled")
   `QMM_ASSERT_IMP(a_empty_after_reset, clock, reset, $past(reset),
      !rsp_valid, "result valid right after reset")

endmodule

>>> design/qmm_mix.sv
// three-stage mixer: gain products, pair sums, per-rotor squared speed
module qmm_mix (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 in_valid,
   output logic                                 in_ready,
   input  logic signed [qmm_pkg::IN_W-1:0]      thrust,
   input  logic signed [qmm_pkg::IN_W-1:0]      roll_moment,
   input  logic signed [qmm_pkg::IN_W-1:0]      pitch_moment,
   input  logic signed [qmm_pkg::IN_W-1:0]      yaw_moment,
   input  qmm_pkg::cfg_type                     cfg,
   output logic                                 out_valid,
   input  logic                                 out_ready,
   output qmm_pkg::rad_type [qmm_pkg::LANES-1:0] rad
);
   import qmm_pkg::*;

   localparam int STAGES = 3;

   logic [STAGES-1:0] valid_ff;
   logic [STAGES:0]   en;

   logic signed [PROD_W-1:0] thr_prod_in, roll_prod_in, pitch_prod_in, yaw_prod_in;
   logic signed [PROD_W-1:0] thr_prod_ff, roll_prod_ff, pitch_prod_ff, yaw_prod_ff;
   logic [PAIR_W-1:0] tr_dif_in, tr_sum_in, py_sum_in, py_dif_in;
   logic [PAIR_W-1:0] tr_dif_ff, tr_sum_ff, py_sum_ff, py_dif_ff;
   logic [SUM_W-1:0]  sum_in [LANES];
   rad_type [LANES-1:0] rad_in, rad_ff;

   always_comb begin
      en[STAGES] = out_ready;
      for (int k = STAGES - 1; k >= 0; k--) begin
         en[k] = !valid_ff[k] || en[k+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (en[0]) begin
            valid_ff[0] <= in_valid;
         end
         for (int k = 1; k < STAGES; k++) begin
            if (en[k]) begin
               valid_ff[k] <= valid_ff[k-1];
            end
         end
      end
   end

   always_comb begin
      thr_prod_in   = thrust       * $signed({1'b0, cfg.thrust_gain});
      roll_prod_in  = roll_moment  * $signed({1'b0, cfg.roll_gain});
      pitch_prod_in = pitch_moment * $signed({1'b0, cfg.pitch_gain});
      yaw_prod_in   = yaw_moment   * $signed({1'b0, cfg.yaw_gain});

      tr_dif_in = {thr_prod_ff[PROD_W-1], thr_prod_ff} - {roll_prod_ff[PROD_W-1], roll_prod_ff};
      tr_sum_in = {thr_prod_ff[PROD_W-1], thr_prod_ff} + {roll_prod_ff[PROD_W-1], roll_prod_ff};
      py_sum_in = {pitch_prod_ff[PROD_W-1], pitch_prod_ff}
                + {yaw_prod_ff[PROD_W-1], yaw_prod_ff};
      py_dif_in = {pitch_prod_ff[PROD_W-1], pitch_prod_ff}
                - {yaw_prod_ff[PROD_W-1], yaw_prod_ff};

      sum_in[LANE_BL] = {tr_dif_ff[PAIR_W-1], tr_dif_ff} - {py_sum_ff[PAIR_W-1], py_sum_ff};
      sum_in[LANE_FL] = {tr_sum_ff[PAIR_W-1], tr_sum_ff} - {py_dif_ff[PAIR_W-1], py_dif_ff};
      sum_in[LANE_BR] = {tr_dif_ff[PAIR_W-1], tr_dif_ff} + {py_sum_ff[PAIR_W-1], py_sum_ff};
      sum_in[LANE_FR] = {tr_sum_ff[PAIR_W-1], tr_sum_ff} + {py_dif_ff[PAIR_W-1], py_dif_ff};

      // non-positive square maps to zero speed
      for (int l = 0; l < LANES; l++) begin
         rad_in[l] = (!sum_in[l][SUM_W-1] && (|sum_in[l])) ? sum_in[l][RAD_W-1:0] : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         thr_prod_ff   <= thr_prod_in;
         roll_prod_ff  <= roll_prod_in;
         pitch_prod_ff <= pitch_prod_in;
         yaw_prod_ff   <= yaw_prod_in;
      end
      if (en[1]) begin
         tr_dif_ff <= tr_dif_in;
         tr_sum_ff <= tr_sum_in;
         py_sum_ff <= py_sum_in;
         py_dif_ff <= py_dif_in;
      end
      if (en[2]) begin
         rad_ff <= rad_in;
      end
   end

   assign in_ready  = en[0];
   assign out_valid = valid_ff[STAGES-1];
   assign rad       = rad_ff;

endmodule

>>> design/qmm_sqrt.sv
// pipelined integer square root, two root bits per stage, four lanes
module qmm_sqrt (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  in_valid,
   output logic                                  in_ready,
   input  qmm_pkg::rad_type [qmm_pkg::LANES-1:0]  rad,
   output logic                                  out_valid,
   input  logic                                  out_ready,
   output qmm_pkg::root_type [qmm_pkg::LANES-1:0] root
);
   import qmm_pkg::*;

   localparam int STAGES = SQRT_STAGES;

   typedef logic [REM_W-1:0] rem_type;

   typedef struct packed {
      rem_type  rem;
      root_type root;
   } step_type;

   function automatic step_type sqrt_step(input rem_type rem, input root_type rt,
                                          input logic [1:0] pair);
      rem_type  acc;
      rem_type  trial;
      step_type res;
      acc   = {rem[REM_W-3:0], pair};
      trial = {rt, 2'b01};
      if (acc >= trial) begin
         res.rem  = acc - trial;
         res.root = {rt[ROOT_W-2:0], 1'b1};
      end else begin
         res.rem  = acc;
         res.root = {rt[ROOT_W-2:0], 1'b0};
      end
      return res;
   endfunction

   logic [STAGES-1:0] valid_ff;
   logic [STAGES:0]   en;

   rad_type  [LANES-1:0] rad_ff  [STAGES];
   rem_type  [LANES-1:0] rem_ff  [STAGES];
   root_type [LANES-1:0] root_ff [STAGES];

   always_comb begin
      en[STAGES] = out_ready;
      for (int k = STAGES - 1; k >= 0; k--) begin
         en[k] = !valid_ff[k] || en[k+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (en[0]) begin
            valid_ff[0] <= in_valid;
         end
         for (int k = 1; k < STAGES; k++) begin
            if (en[k]) begin
               valid_ff[k] <= valid_ff[k-1];
            end
         end
      end
   end

   for (genvar k = 0; k < STAGES; k++) begin : g_stage
      rad_type  [LANES-1:0] rad_src;
      rem_type  [LANES-1:0] rem_src;
      root_type [LANES-1:0] root_src;
      rad_type  [LANES-1:0] rad_in;
      rem_type  [LANES-1:0] rem_in;
      root_type [LANES-1:0] root_in;

      if (k == 0) begin : g_first
         assign rad_src  = rad;
         assign rem_src  = '0;
         assign root_src = '0;
      end else begin : g_next
         assign rad_src  = rad_ff[k-1];
         assign rem_src  = rem_ff[k-1];
         assign root_src = root_ff[k-1];
      end

      always_comb begin
         step_type first;
         step_type second;
         for (int l = 0; l < LANES; l++) begin
            first      = sqrt_step(rem_src[l], root_src[l], rad_src[l][RAD_W-1 -: 2]);
            second     = sqrt_step(first.rem, first.root, rad_src[l][RAD_W-3 -: 2]);
            rem_in[l]  = second.rem;
            root_in[l] = second.root;
            rad_in[l]  = rad_src[l] << (2 * SQRT_BITS_PER_STAGE);
         end
      end

      always_ff @(posedge clock) begin
         if (en[k]) begin
            rad_ff[k]  <= rad_in;
            rem_ff[k]  <= rem_in;
            root_ff[k] <= root_in;
         end
      end
   end

   assign in_ready  = en[0];
   assign out_valid = valid_ff[STAGES-1];
   assign root      = root_ff[STAGES-1];

endmodule

>>> design/qmm_curve.sv
// three-stage inverse motor curve: offset, slope product, segment pick and clamp
module qmm_curve (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      in_valid,
   output logic                                      in_ready,
   input  qmm_pkg::root_type [qmm_pkg::LANES-1:0]     root,
   input  qmm_pkg::cfg_type                          cfg,
   output logic                                      out_valid,
   input  logic                                      out_ready,
   output qmm_pkg::throttle_type [qmm_pkg::LANES-1:0] throttle
);
   import qmm_pkg::*;

   localparam int STAGES = 3;

   logic [STAGES-1:0] valid_ff;
   logic [STAGES:0]   en;

   logic signed [DIFF_W-1:0]  dlo_in [LANES], dhi_in [LANES];
   logic signed [DIFF_W-1:0]  dlo_ff [LANES], dhi_ff [LANES];
   logic signed [CURVE_W-1:0] tlo_in [LANES], thi_in [LANES];
   logic signed [CURVE_W-1:0] tlo_ff [LANES], thi_ff [LANES];
   throttle_type [LANES-1:0]  thr_in, thr_ff;

   always_comb begin
      en[STAGES] = out_ready;
      for (int k = STAGES - 1; k >= 0; k--) begin
         en[k] = !valid_ff[k] || en[k+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (en[0]) begin
            valid_ff[0] <= in_valid;
         end
         for (int k = 1; k < STAGES; k++) begin
            if (en[k]) begin
               valid_ff[k] <= valid_ff[k-1];
            end
         end
      end
   end

   always_comb begin
      logic signed [CURVE_W-1:0] chosen;
      logic [WHOLE_W-1:0]        whole;
      for (int l = 0; l < LANES; l++) begin
         dlo_in[l] = $signed({1'b0, root[l]})
                   - $signed({{(DIFF_W-OFFSET_W){1'b0}}, cfg.low_offset});
         dhi_in[l] = $signed({1'b0, root[l]})
                   - $signed({{(DIFF_W-OFFSET_W){1'b0}}, cfg.high_offset});

         tlo_in[l] = dlo_ff[l] * $signed({1'b0, cfg.low_inv_slope});
         thi_in[l] = dhi_ff[l] * $signed({1'b0, cfg.high_inv_slope});

         // low segment holds up to the crossover throttle
         chosen = (tlo_ff[l] > CROSSOVER) ? thi_ff[l] : tlo_ff[l];
         whole  = chosen[CURVE_W-1:CURVE_FRAC];
         if (chosen[CURVE_W-1]) begin
            thr_in[l] = '0;
         end else if (whole > WHOLE_W'(THROTTLE_MAX)) begin
            thr_in[l] = THROTTLE_MAX;
         end else begin
            thr_in[l] = whole[THR_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         dlo_ff <= dlo_in;
         dhi_ff <= dhi_in;
      end
      if (en[1]) begin
         tlo_ff <= tlo_in;
         thi_ff <= thi_in;
      end
      if (en[2]) begin
         thr_ff <= thr_in;
      end
   end

   assign in_ready  = en[0];
   assign out_valid = valid_ff[STAGES-1];
   assign throttle  = thr_ff;

endmodule

>>> sim/quad_motor_mixer_throttle_tb.sv
// testbench for the quad motor mixer throttle block: predicted throttles checked per transaction
`timescale 1ns / 1ps

module quad_motor_mixer_throttle_tb;
   import qmm_pkg::*;

   localparam int PIPE_SETTLE = 25;

   typedef struct packed {
      logic signed [IN_W-1:0] thrust;
      logic signed [IN_W-1:0] roll;
      logic signed [IN_W-1:0] pitch;
      logic signed [IN_W-1:0] yaw;
   } demand_type;

   typedef struct packed {
      throttle_type back_left;
      throttle_type front_left;
      throttle_type back_right;
      throttle_type front_right;
   } throttle_set_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [IN_W-1:0] req_thrust = '0;
   logic signed [IN_W-1:0] req_roll_moment = '0;
   logic signed [IN_W-1:0] req_pitch_moment = '0;
   logic signed [IN_W-1:0] req_yaw_moment = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   throttle_type rsp_throttle_back_left;
   throttle_type rsp_throttle_front_left;
   throttle_type rsp_throttle_back_right;
   throttle_type rsp_throttle_front_right;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [GAIN_W-1:0] csr_data = '0;

   cfg_type mixer_cfg = CFG_RESET;
   demand_type pending_demands[$];
   throttle_set_type expected_throttles[$];
   demand_type in_flight;
   throttle_set_type observed;
   throttle_set_type wanted;
   int unsigned send_idle = 0;
   int unsigned recv_stall = 0;
   int unsigned mismatch_count = 0;

   quad_motor_mixer_throttle dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_thrust(req_thrust),
      .req_roll_moment(req_roll_moment),
      .req_pitch_moment(req_pitch_moment),
      .req_yaw_moment(req_yaw_moment),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_throttle_back_left(rsp_throttle_back_left),
      .rsp_throttle_front_left(rsp_throttle_front_left),
      .rsp_throttle_back_right(rsp_throttle_back_right),
      .rsp_throttle_front_right(rsp_throttle_front_right),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always #5 clock = ~clock;

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned root;
      longint unsigned probe;
      root = 0;
      probe = 64'd1 << 62;
      while (probe > v)
         probe >>= 2;
      while (probe != 0) begin
         if (v >= root + probe) begin
            v -= root + probe;
            root = (root >> 1) + probe;
         end else begin
            root >>= 1;
         end
         probe >>= 2;
      end
      return root;
   endfunction

   function automatic throttle_type rotor_throttle(longint sq);
      longint w;
      longint level;
      if (sq <= 0)
         return '0;
      w = longint'(int_sqrt(sq));
      level = (w - longint'(mixer_cfg.low_offset)) * longint'(mixer_cfg.low_inv_slope);
      if (level > (longint'(CROSS_THROTTLE) << CURVE_FRAC))
         level = (w - longint'(mixer_cfg.high_offset)) * longint'(mixer_cfg.high_inv_slope);
      if (level < 0)
         return '0;
      level = level >>> CURVE_FRAC;
      if (level > longint'(THROTTLE_MAX))
         return THROTTLE_MAX;
      return throttle_type'(level);
   endfunction

   function automatic throttle_set_type mix_to_throttles(demand_type d);
      longint t, r, p, y;
      throttle_set_type s;
      t = longint'(d.thrust) * longint'(mixer_cfg.thrust_gain);
      r = longint'(d.roll) * longint'(mixer_cfg.roll_gain);
      p = longint'(d.pitch) * longint'(mixer_cfg.pitch_gain);
      y = longint'(d.yaw) * longint'(mixer_cfg.yaw_gain);
      s.back_left   = rotor_throttle(t - r - p - y);
      s.front_left  = rotor_throttle(t + r - p + y);
      s.back_right  = rotor_throttle(t - r + p + y);
      s.front_right = rotor_throttle(t + r + p - y);
      return s;
   endfunction

   function automatic logic signed [IN_W-1:0] scaled_value();
      return $signed($urandom) >>> $urandom_range(31, 0);
   endfunction

   function automatic demand_type random_demand();
      demand_type d;
      if ($urandom_range(9) < 5) begin
         // flight-like range for the default gains
         d.thrust = $urandom_range(30 * 65536);
         d.roll   = int'($urandom_range(2 * 65536)) - 65536;
         d.pitch  = int'($urandom_range(2 * 65536)) - 65536;
         d.yaw    = int'($urandom_range(26214)) - 13107;
      end else begin
         d.thrust = scaled_value();
         d.roll   = scaled_value();
         d.pitch  = scaled_value();
         d.yaw    = scaled_value();
      end
      return d;
   endfunction

   function automatic cfg_type random_config();
      cfg_type c;
      c.roll_gain      = GAIN_W'($urandom >> $urandom_range(31, 6));
      c.pitch_gain     = GAIN_W'($urandom >> $urandom_range(31, 6));
      c.yaw_gain       = GAIN_W'($urandom >> $urandom_range(31, 6));
      c.thrust_gain    = GAIN_W'($urandom >> $urandom_range(31, 6));
      c.low_offset     = OFFSET_W'($urandom >> $urandom_range(31, 8));
      c.low_inv_slope  = SLOPE_W'($urandom);
      c.high_offset    = OFFSET_W'($urandom >> $urandom_range(31, 8));
      c.high_inv_slope = SLOPE_W'($urandom);
      return c;
   endfunction

   task automatic push_demand(input logic signed [IN_W-1:0] thrust, roll, pitch, yaw);
      demand_type d;
      d.thrust = thrust;
      d.roll   = roll;
      d.pitch  = pitch;
      d.yaw    = yaw;
      pending_demands.push_back(d);
   endtask

   task automatic push_random(input int count);
      repeat (count) pending_demands.push_back(random_demand());
   endtask

   task automatic wait_idle();
      while (pending_demands.size() != 0 || req_valid || expected_throttles.size() != 0)
         @(posedge clock);
      repeat (PIPE_SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [GAIN_W-1:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         REG_ROLL_GAIN:      mixer_cfg.roll_gain      = data;
         REG_PITCH_GAIN:     mixer_cfg.pitch_gain     = data;
         REG_YAW_GAIN:       mixer_cfg.yaw_gain       = data;
         REG_THRUST_GAIN:    mixer_cfg.thrust_gain    = data;
         REG_LOW_OFFSET:     mixer_cfg.low_offset     = data[OFFSET_W-1:0];
         REG_LOW_INV_SLOPE:  mixer_cfg.low_inv_slope  = data[SLOPE_W-1:0];
         REG_HIGH_OFFSET:    mixer_cfg.high_offset    = data[OFFSET_W-1:0];
         REG_HIGH_INV_SLOPE: mixer_cfg.high_inv_slope = data[SLOPE_W-1:0];
         default: ;
      endcase
   endtask

   task automatic program_config(input cfg_type c, input bit dirty_upper);
      logic [GAIN_W-1:0] junk;
      junk = dirty_upper ? GAIN_W'($urandom) : '0;
      write_reg(REG_ROLL_GAIN, c.roll_gain);
      write_reg(REG_PITCH_GAIN, c.pitch_gain);
      write_reg(REG_YAW_GAIN, c.yaw_gain);
      write_reg(REG_THRUST_GAIN, c.thrust_gain);
      write_reg(REG_LOW_OFFSET, {junk[GAIN_W-1:OFFSET_W], c.low_offset});
      write_reg(REG_LOW_INV_SLOPE, {junk[GAIN_W-1:SLOPE_W], c.low_inv_slope});
      write_reg(REG_HIGH_OFFSET, {junk[GAIN_W-1:OFFSET_W], c.high_offset});
      write_reg(REG_HIGH_INV_SLOPE, {junk[GAIN_W-1:SLOPE_W], c.high_inv_slope});
      // unmapped index must leave every register alone
      write_reg(CSR_INDEX_W'($urandom_range(15, 8)), GAIN_W'($urandom));
   endtask

   task automatic check_lane(input string lane, input throttle_type want, got);
      if (want !== got) begin
         $display("%0t: %s throttle mismatch, expected %0d actual %0d", $time, lane, want, got);
         mismatch_count++;
      end
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready)
            expected_throttles.push_back(mix_to_throttles(in_flight));
         if (!req_valid || req_ready) begin
            if (pending_demands.size() != 0 && $urandom_range(99) >= send_idle) begin
               in_flight = pending_demands.pop_front();
               req_valid        <= 1'b1;
               req_thrust       <= in_flight.thrust;
               req_roll_moment  <= in_flight.roll;
               req_pitch_moment <= in_flight.pitch;
               req_yaw_moment   <= in_flight.yaw;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            observed.back_left   = rsp_throttle_back_left;
            observed.front_left  = rsp_throttle_front_left;
            observed.back_right  = rsp_throttle_back_right;
            observed.front_right = rsp_throttle_front_right;
            if (expected_throttles.size() == 0) begin
               $display("%0t: unexpected transaction, expected none actual %0d %0d %0d %0d",
                        $time, observed.back_left, observed.front_left,
                        observed.back_right, observed.front_right);
               mismatch_count++;
            end else begin
               wanted = expected_throttles.pop_front();
               check_lane("back left", wanted.back_left, observed.back_left);
               check_lane("front left", wanted.front_left, observed.front_left);
               check_lane("back right", wanted.back_right, observed.back_right);
               check_lane("front right", wanted.front_right, observed.front_right);
            end
         end
         rsp_ready <= ($urandom_range(99) >= recv_stall);
      end
   end

   initial begin
      #2_000_000;
      $display("TEST FAILED");
      $finish;
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed, reset configuration
      send_idle  = 0;
      recv_stall = 0;
      push_demand(32'sd0, 32'sd0, 32'sd0, 32'sd0);
      push_demand(32'sh7FFFFFFF, 32'sd0, 32'sd0, 32'sd0);
      push_demand(32'sh80000000, 32'sd0, 32'sd0, 32'sd0);
      push_demand(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF);
      push_demand(32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000);
      push_demand(32'sd0, 32'sh7FFFFFFF, 32'sd0, 32'sd0);
      push_demand(32'sd0, 32'sh80000000, 32'sd0, 32'sd0);
      push_demand(32'sd0, 32'sd0, 32'sh7FFFFFFF, 32'sd0);
      push_demand(32'sd0, 32'sd0, 32'sh80000000, 32'sd0);
      push_demand(32'sd0, 32'sd0, 32'sd0, 32'sh7FFFFFFF);
      push_demand(32'sd0, 32'sd0, 32'sd0, 32'sh80000000);
      push_demand(32'sd655360, 32'sd0, 32'sd0, 32'sd0);
      push_demand(32'sd196608, 32'sd0, 32'sd0, 32'sd0);
      push_demand(32'sd229376, 32'sd0, 32'sd0, 32'sd0);
      push_demand(32'sd1376256, 32'sd0, 32'sd0, 32'sd0);
      push_demand(32'sd1, 32'sd0, 32'sd0, 32'sd0);
      push_demand(32'sd65536, 32'sd32768, 32'sd0, 32'sd0);
      push_demand(32'sd524288, 32'sd19661, -32'sd13107, 32'sd3277);
      push_demand(32'sd65536, 32'sd0, 32'sd0, 32'sd0);
      push_demand(32'sd0, 32'sd1, -32'sd1, 32'sd1);
      wait_idle();

      // bursty sender, paused halfway until the pipeline drains
      send_idle = 63;
      push_random(125);
      wait_idle();
      push_random(125);
      wait_idle();

      program_config('1, 1'b1);
      send_idle  = 0;
      recv_stall = 63;
      push_demand(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF);
      push_demand(32'sh7FFFFFFF, 32'sd0, 32'sd0, 32'sd0);
      push_random(150);
      wait_idle();

      program_config('0, 1'b0);
      send_idle  = 19;
      recv_stall = 19;
      push_random(100);
      wait_idle();

      program_config(random_config(), 1'b1);
      send_idle  = 0;
      recv_stall = 0;
      push_random(200);
      wait_idle();

      program_config(CFG_RESET, 1'b1);
      send_idle  = 19;
      recv_stall = 19;
      push_random(125);
      wait_idle();
      send_idle  = 0;
      recv_stall = 63;
      push_random(125);
      wait_idle();

      if (mismatch_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
